// ----- rtl/swm_pkg.sv -----
package swm_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int WL_W           = 6;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 6;
	localparam int MAX_WINDOW_DEF = 32;
	localparam int JOB_FIFO_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAKE_MAXIMUM  = 1'd1;

	localparam logic [WL_W-1:0] WINDOW_LENGTH_RST = 6'd5;
	localparam logic            TAKE_MAXIMUM_RST  = 1'b1;

endpackage

// ----- rtl/swm_in_if.sv -----
interface swm_in_if
	import swm_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       end_of_sequence;

	modport source (output valid, output sample, output end_of_sequence, input ready);
	modport sink (input valid, input sample, input end_of_sequence, output ready);
endinterface

// ----- rtl/swm_out_if.sv -----
interface swm_out_if
	import swm_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] extreme_value;
	logic                       final_result;

	modport source (output valid, output extreme_value, output final_result, input ready);
	modport sink (input valid, input extreme_value, input final_result, output ready);
endinterface

// ----- rtl/swm_ram.sv -----
module swm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/swm_fifo.sv -----
module swm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign empty      = (count_q == '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && !empty;
	assign pop_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ----- rtl/swm_front.sv -----
module swm_front
	import swm_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int AW = $clog2(MAX_WINDOW),
	localparam int SW = $clog2(MAX_WINDOW + 1),
	localparam int JW = AW + SW + 2
) (
	input  logic                clk,
	input  logic                arst_n,
	swm_in_if.sink              in_ch,
	input  logic [WL_W-1:0]     window_length,
	input  logic                take_maximum,
	output logic                ram_we,
	output logic [AW-1:0]       ram_waddr,
	output logic [SAMPLE_W-1:0] ram_wdata,
	output logic                job_valid,
	input  logic                job_ready,
	output logic [JW-1:0]       job_data,
	input  logic                queue_empty,
	input  logic                back_busy
);
	localparam int PW = $clog2(MAX_WINDOW / 2 + 2);
	localparam int EW = (SW > WL_W) ? SW : WL_W;

	localparam logic F_IDLE = 1'b0;
	localparam logic F_EMIT = 1'b1;

	typedef struct packed {
		logic [AW-1:0] addr;
		logic [SW-1:0] len;
		logic          final_result;
		logic          take_max;
	} job_t;

	logic          state_q;
	logic [AW-1:0] wp_q;
	logic [SW-1:0] seen_q;
	logic [PW-1:0] lag_q;
	logic [PW-1:0] d_q;
	logic [PW-1:0] rem_q;
	logic [PW-1:0] n1_q;
	logic [PW-1:0] n2_q;
	logic          last_q;
	logic          tmax_q;

	logic          accept;
	logic [EW-1:0] wl_ext;
	logic [SW-1:0] w_eff;
	logic [SW-1:0] w_m1;
	logic [PW-1:0] n1;
	logic [PW-1:0] n2;
	logic [PW-1:0] pending;
	logic [PW-1:0] count;

	logic [SW-1:0] d_ext;
	logic [SW-1:0] lo_raw;
	logic [SW-1:0] reach;
	logic [SW-1:0] seen_m1;
	logic [SW-1:0] hi;
	logic [SW-1:0] lo;
	logic [AW:0]   addr_raw;
	job_t          job;

	assign in_ch.ready = (state_q == F_IDLE) && queue_empty && !back_busy;
	assign accept      = in_ch.valid && in_ch.ready;

	assign ram_we    = accept;
	assign ram_waddr = wp_q;
	assign ram_wdata = in_ch.sample;

	// clamp window length into 1..MAX_WINDOW
	always_comb begin
		wl_ext = EW'(window_length);
		if (wl_ext == '0) begin
			w_eff = SW'(1);
		end else if (wl_ext > EW'(MAX_WINDOW)) begin
			w_eff = SW'(MAX_WINDOW);
		end else begin
			w_eff = SW'(wl_ext);
		end
		w_m1    = w_eff - SW'(1);
		n1      = PW'(w_m1 >> 1);
		n2      = PW'(w_eff >> 1);
		pending = lag_q + PW'(1);
		if (in_ch.end_of_sequence) begin
			count = pending;
		end else if (pending > n2) begin
			count = pending - n2;
		end else begin
			count = '0;
		end
	end

	// window bounds for position d_q samples back from the newest
	always_comb begin
		d_ext   = SW'(d_q);
		lo_raw  = (d_ext > SW'(n2_q)) ? d_ext - SW'(n2_q) : '0;
		reach   = d_ext + SW'(n1_q);
		seen_m1 = seen_q - SW'(1);
		hi      = (reach > seen_m1) ? seen_m1 : reach;
		lo      = (lo_raw > hi) ? hi : lo_raw;
		addr_raw = {1'b0, wp_q} + (AW + 1)'(MAX_WINDOW - 1) - (AW + 1)'(lo);
		if (addr_raw >= (AW + 1)'(MAX_WINDOW)) begin
			addr_raw = addr_raw - (AW + 1)'(MAX_WINDOW);
		end
		job.addr         = AW'(addr_raw);
		job.len          = hi - lo + SW'(1);
		job.final_result = last_q && (rem_q == PW'(1));
		job.take_max     = tmax_q;
	end

	assign job_valid = (state_q == F_EMIT);
	assign job_data  = job;

	always_ff @(posedge clk) begin
		if (accept) begin
			n1_q   <= n1;
			n2_q   <= n2;
			last_q <= in_ch.end_of_sequence;
			tmax_q <= take_maximum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			wp_q    <= '0;
			seen_q  <= '0;
			lag_q   <= '0;
			d_q     <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						wp_q   <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + AW'(1);
						seen_q <= (seen_q == SW'(MAX_WINDOW)) ? seen_q : seen_q + SW'(1);
						lag_q  <= pending - count;
						d_q    <= pending - PW'(1);
						rem_q  <= count;
						if (count != '0) begin
							state_q <= F_EMIT;
						end
					end
				end
				F_EMIT: begin
					if (job_ready) begin
						d_q   <= d_q - PW'(1);
						rem_q <= rem_q - PW'(1);
						if (rem_q == PW'(1)) begin
							state_q <= F_IDLE;
							if (last_q) begin
								wp_q   <= '0;
								seen_q <= '0;
								lag_q  <= '0;
							end
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/swm_back.sv -----
module swm_back
	import swm_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int AW = $clog2(MAX_WINDOW),
	localparam int SW = $clog2(MAX_WINDOW + 1),
	localparam int JW = AW + SW + 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                queue_empty,
	input  logic [JW-1:0]       job_data,
	output logic                job_pop,
	output logic                ram_re,
	output logic [AW-1:0]       ram_raddr,
	input  logic [SAMPLE_W-1:0] ram_rdata,
	swm_out_if.source           out_ch,
	output logic                busy
);
	localparam logic [1:0] B_IDLE  = 2'd0;
	localparam logic [1:0] B_READ  = 2'd1;
	localparam logic [1:0] B_DRAIN = 2'd2;
	localparam logic [1:0] B_OUT   = 2'd3;

	typedef struct packed {
		logic [AW-1:0] addr;
		logic [SW-1:0] len;
		logic          final_result;
		logic          take_max;
	} job_t;

	logic [1:0]                 state_q;
	logic [AW-1:0]              addr_q;
	logic [SW-1:0]              rem_q;
	logic                       first_q;
	logic                       tmax_q;
	logic                       final_q;
	logic                       valid_s1;
	logic                       first_s1;
	logic signed [SAMPLE_W-1:0] best_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_value_q;
	logic                       out_final_q;

	job_t                       job;
	logic signed [SAMPLE_W-1:0] rd_val;
	logic                       better;
	logic                       load_out;

	assign job       = job_t'(job_data);
	assign job_pop   = (state_q == B_IDLE) && !queue_empty;
	assign ram_re    = (state_q == B_READ);
	assign ram_raddr = addr_q;
	assign busy      = (state_q == B_READ) || (state_q == B_DRAIN);

	assign rd_val   = $signed(ram_rdata);
	assign better   = tmax_q ? (rd_val > best_q) : (rd_val < best_q);
	assign load_out = (state_q == B_OUT) && (!out_valid_q || out_ch.ready);

	assign out_ch.valid         = out_valid_q;
	assign out_ch.extreme_value = out_value_q;
	assign out_ch.final_result  = out_final_q;

	always_ff @(posedge clk) begin
		if (job_pop) begin
			tmax_q  <= job.take_max;
			final_q <= job.final_result;
		end
		if (valid_s1 && (first_s1 || better)) begin
			best_q <= rd_val;
		end
		if (load_out) begin
			out_value_q <= best_q;
			out_final_q <= final_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			addr_q      <= '0;
			rem_q       <= '0;
			first_q     <= 1'b0;
			valid_s1    <= 1'b0;
			first_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= (state_q == B_READ);
			first_s1 <= (state_q == B_READ) && first_q;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (job_pop) begin
						addr_q  <= job.addr;
						rem_q   <= job.len;
						first_q <= 1'b1;
						state_q <= B_READ;
					end
				end
				B_READ: begin
					// walk toward older samples, one history read a cycle
					addr_q  <= (addr_q == '0) ? AW'(MAX_WINDOW - 1) : addr_q - AW'(1);
					rem_q   <= rem_q - SW'(1);
					first_q <= 1'b0;
					if (rem_q == SW'(1)) begin
						state_q <= B_DRAIN;
					end
				end
				B_DRAIN: state_q <= B_OUT;
				B_OUT: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/sliding_window_min_max_filter_top.sv -----
// Channel   Dir   Payload                                  Handshake
// in_ch     in    sample[15:0] signed, end_of_sequence     valid / ready
// out_ch    out   extreme_value[15:0] signed, final_result valid / ready
// cfg       in    cfg_index, cfg_data[5:0]                 cfg_we, no wait
//
// Items that release no result can stream at one per cycle while no job is queued and the back unit is not reading.
// For each result, the back unit reads the history
// RAM one entry per cycle through its single read port.
// The next item is taken once all results of the previous one have been computed.
// arst_n clears control state only; the history RAM is not cleared.
// A stalled output holds the last result in the output register; the back unit then waits.
module sliding_window_min_max_filter_top
	import swm_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	swm_in_if.sink                in_ch,
	swm_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int AW = $clog2(MAX_WINDOW);
	localparam int SW = $clog2(MAX_WINDOW + 1);
	localparam int JW = AW + SW + 2;

	logic [WL_W-1:0]     window_length_q;
	logic                take_maximum_q;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [SAMPLE_W-1:0] ram_wdata;
	logic                ram_re;
	logic [AW-1:0]       ram_raddr;
	logic [SAMPLE_W-1:0] ram_rdata;

	logic                job_valid;
	logic                job_ready;
	logic [JW-1:0]       job_in;
	logic [JW-1:0]       job_out;
	logic                job_pop;
	logic                queue_empty;
	logic                back_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RST;
			take_maximum_q  <= TAKE_MAXIMUM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_LENGTH: window_length_q <= cfg_data[WL_W-1:0];
				CFG_TAKE_MAXIMUM:  take_maximum_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	swm_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_ch         (in_ch),
		.window_length (window_length_q),
		.take_maximum  (take_maximum_q),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.job_valid     (job_valid),
		.job_ready     (job_ready),
		.job_data      (job_in),
		.queue_empty   (queue_empty),
		.back_busy     (back_busy)
	);

	swm_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_history (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	swm_fifo #(.WIDTH(JW), .DEPTH(JOB_FIFO_DEPTH)) u_job_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_valid),
		.push_ready (job_ready),
		.push_data  (job_in),
		.pop        (job_pop),
		.empty      (queue_empty),
		.pop_data   (job_out)
	);

	swm_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.job_data    (job_out),
		.job_pop     (job_pop),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.out_ch      (out_ch),
		.busy        (back_busy)
	);

	// history must not change under an in-progress window scan
	a_no_write_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !back_busy && !ram_re)
		else $error("history written while window scan in progress");

	// a transfer in only happens once all queued jobs are drained
	a_accept_queue_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> queue_empty && !job_valid)
		else $error("input transfer with jobs still queued");

	// the last sample always releases at least one result, so the front must stall
	a_last_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.end_of_sequence) |=> !in_ch.ready)
		else $error("no flush after end of sequence");
endmodule

// ----- dv/window_extreme_checker.sv -----
`timescale 1ns / 1ps
module window_extreme_checker
	import swm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	swm_in_if                     in_ch,
	swm_out_if                    out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    outstanding,
	output int                    mismatches,
	output int                    checked
);

	localparam int HIST = MAX_WINDOW_DEF;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic                       last;
	} extreme_t;

	logic signed [SAMPLE_W-1:0] history [HIST];
	int                         wr_pos;
	int                         seen;
	int                         lag;
	logic [WL_W-1:0]            win_len;
	logic                       take_max;
	extreme_t                   expected_extremes [$];
	extreme_t                   want;

	task automatic report_mismatch(string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatches++;
	endtask

	// back = 0 is the newest sample
	function automatic logic signed [SAMPLE_W-1:0] history_back(int back);
		return history[(wr_pos + HIST - 1 - back) % HIST];
	endfunction

	// d counts back from the newest sample; window clipped to what this sequence holds
	function automatic logic signed [SAMPLE_W-1:0] clipped_extreme(int d, int n1, int n2);
		int                         lo;
		int                         hi;
		logic signed [SAMPLE_W-1:0] best;
		logic signed [SAMPLE_W-1:0] v;
		lo = (d > n2) ? d - n2 : 0;
		hi = d + n1;
		if (hi > seen - 1)
			hi = seen - 1;
		if (lo > hi)
			lo = hi;
		best = history_back(lo);
		for (int b = lo + 1; b <= hi; b++) begin
			v = history_back(b);
			if (take_max ? (v > best) : (v < best))
				best = v;
		end
		return best;
	endfunction

	function automatic void predict_extremes(logic signed [SAMPLE_W-1:0] s, logic eos);
		int       w;
		int       n1;
		int       n2;
		int       pending;
		int       count;
		extreme_t e;
		w = int'(win_len);
		if (w == 0)
			w = 1;
		if (w > HIST)
			w = HIST;
		n1 = (w - 1) / 2;
		n2 = w / 2;
		history[wr_pos] = s;
		wr_pos = (wr_pos + 1) % HIST;
		if (seen < HIST)
			seen++;
		pending = lag + 1;
		if (eos)
			count = pending;
		else
			count = (pending > n2) ? pending - n2 : 0;
		// oldest pending position first
		for (int k = 0; k < count; k++) begin
			e.value = clipped_extreme(pending - 1 - k, n1, n2);
			e.last = eos && (k == count - 1);
			expected_extremes.push_back(e);
		end
		if (eos) begin
			wr_pos = 0;
			seen = 0;
			lag = 0;
		end else begin
			lag = pending - count;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HIST; i++)
				history[i] = '0;
			wr_pos = 0;
			seen = 0;
			lag = 0;
			win_len = WINDOW_LENGTH_RST;
			take_max = TAKE_MAXIMUM_RST;
			expected_extremes.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WINDOW_LENGTH: win_len = cfg_data[WL_W-1:0];
					CFG_TAKE_MAXIMUM: take_max = cfg_data[0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				predict_extremes(in_ch.sample, in_ch.end_of_sequence);
			if (out_ch.valid && out_ch.ready) begin
				if (expected_extremes.size() == 0) begin
					report_mismatch($sformatf("output transfer with no result expected, value %0d",
						$signed(out_ch.extreme_value)));
				end else begin
					want = expected_extremes.pop_front();
					checked++;
					if (out_ch.extreme_value !== want.value)
						report_mismatch($sformatf("extreme_value got %0d want %0d (result %0d)",
							$signed(out_ch.extreme_value), want.value, checked));
					if (out_ch.final_result !== want.last)
						report_mismatch($sformatf("final_result got %b want %b (result %0d)",
							out_ch.final_result, want.last, checked));
				end
			end
			outstanding <= expected_extremes.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import swm_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 9;
	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 190;
	localparam int PHASE_ITEMS   = 30;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int outstanding;
	int mismatches;
	int checked;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int cycles;
	int samples_sent = 0;
	int seqs_sent = 0;
	int phases = 0;

	swm_in_if  in_ch ();
	swm_out_if out_ch ();

	always #(CLK_HALF) clk = ~clk;

	sliding_window_min_max_filter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	window_extreme_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.mismatches  (mismatches),
		.checked     (checked)
	);

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles, %0d results still expected", cycles, outstanding);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// output side: random stalls, plus one long hold-off on request
	initial begin : ready_gen
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// called at a clock edge; returns at the edge of the transfer
	task automatic send_item(logic signed [SAMPLE_W-1:0] s, logic eos);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= s;
		in_ch.end_of_sequence <= eos;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		samples_sent++;
		if (eos)
			seqs_sent++;
	endtask

	// wait for all results, then let any result-free item finish inside the block
	task automatic drain();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [CFG_DATA_W-1:0] wl, logic tm);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WINDOW_LENGTH;
		cfg_data <= wl;
		@(posedge clk);
		// upper bits are don't-care for the flag
		cfg_index <= CFG_TAKE_MAXIMUM;
		cfg_data <= {(CFG_DATA_W-1)'($urandom), tm};
		@(posedge clk);
		cfg_we <= 1'b0;
		phases++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2, 3: return SAMPLE_W'($signed($urandom_range(15)) - 8);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic int pick_length();
		return ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_window();
		case ($urandom_range(7))
			0: return '0;
			1: return CFG_DATA_W'($urandom_range(33, 63));
			2: return CFG_DATA_W'($urandom_range(29, 32));
			3: return CFG_DATA_W'(1);
			default: return CFG_DATA_W'($urandom_range(2, 10));
		endcase
	endfunction

	initial begin : stimulus
		int ph;
		int seq_len;
		int ph_items;
		int rand_start;
		bit open_seq;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_WINDOW_LENGTH;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.sample <= '0;
		in_ch.end_of_sequence <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings (window 5, max): field extremes
		send_item(16'h7FFF, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'sd0, 1'b0);
		send_item(-16'sd1, 1'b0);
		send_item(16'sd1, 1'b1);
		// sequence of a single sample
		send_item(16'h8000, 1'b1);
		drain();

		// zero length behaves as one: each output is its own sample
		set_config('0, 1'b0);
		send_item(16'sd5, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'h7FFF, 1'b1);
		drain();

		// oversized window saturates; sequence shorter than either reach
		set_config('1, 1'b1);
		send_item(16'sd7, 1'b0);
		send_item(-16'sd3, 1'b0);
		send_item(16'h8000, 1'b0);
		send_item(16'sd9, 1'b1);
		drain();

		// retune mid-sequence: forward reach drops 16 -> 1, backlog comes out at once
		set_config(6'd32, 1'b0);
		repeat (6) send_item(pick_sample(), 1'b0);
		drain();
		set_config(6'd2, 1'b0);
		send_item(pick_sample(), 1'b0);
		send_item(pick_sample(), 1'b1);
		drain();

		rand_start = samples_sent;
		ph = 0;
		open_seq = 1'b0;
		while (samples_sent - rand_start < RANDOM_ITEMS) begin
			case (ph % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 56;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 56;
				end
				default: begin
					idle_pct = 31;
					stall_pct = 31;
				end
			endcase
			set_config(pick_window(), 1'($urandom));
			// long output hold while input keeps streaming
			if (ph == 0)
				hold_req++;
			ph_items = 0;
			while (ph_items < PHASE_ITEMS) begin
				seq_len = pick_length();
				for (int i = 0; i < seq_len; i++)
					send_item(pick_sample(), i == seq_len - 1);
				ph_items += seq_len;
			end
			// sometimes leave a sequence open across the next config change
			open_seq = 1'b0;
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 5)) send_item(pick_sample(), 1'b0);
				open_seq = 1'b1;
			end
			drain();
			ph++;
		end
		if (open_seq) begin
			send_item(pick_sample(), 1'b1);
			drain();
		end

		$display("Run covered %0d samples in %0d sequences over %0d settings, %0d outputs checked",
			samples_sent, seqs_sent, phases, checked);
		$display("Windows zero through oversized, min and max, retuning inside a sequence, long hold");
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/swm_pkg.sv
rtl/swm_in_if.sv
rtl/swm_out_if.sv
rtl/swm_ram.sv
rtl/swm_fifo.sv
rtl/swm_front.sv
rtl/swm_back.sv
rtl/sliding_window_min_max_filter_top.sv
dv/window_extreme_checker.sv
dv/tb_top.sv
